### src/rbsi_pkg.sv
// shared types and constants for the ray/box slab intersection pipeline
// no dependencies
`default_nettype none

package rbsi_pkg;

  localparam int unsigned AXES      = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_e;

  // per-axis side information that rides along with the quotients
  typedef struct packed {
    logic num_lo_neg;  // box_min - origin is negative
    logic num_hi_neg;  // box_max - origin is negative
    logic dir_neg;     // direction component is negative
    logic dir_zero;    // direction component is zero, axis is parallel
    logic par_miss;    // origin outside the slab on this axis
  } slab_flags_t;

endpackage

`default_nettype wire

### src/rbsi_slab_prep.sv
// input stage for one axis: bound differences, magnitudes and flags
// depends on rbsi_pkg
`default_nettype none

module rbsi_slab_prep
  import rbsi_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic signed [DATA_W-1:0] origin_i,
  input  wire logic signed [DATA_W-1:0] dir_i,
  input  wire logic signed [DATA_W-1:0] lo_i,
  input  wire logic signed [DATA_W-1:0] hi_i,
  output logic                          valid_o,
  output logic [DATA_W:0]               num_lo_o,
  output logic [DATA_W:0]               num_hi_o,
  output logic [DATA_W-1:0]             den_o,
  output slab_flags_t                   flags_o
);

  logic signed [DATA_W:0] diff_lo, diff_hi;
  logic                   valid_q;
  logic [DATA_W:0]        num_lo_d, num_hi_d, num_lo_q, num_hi_q;
  logic [DATA_W-1:0]      den_d, den_q;
  slab_flags_t            flags_d, flags_q;

  always_comb begin
    diff_lo = $signed({lo_i[DATA_W-1], lo_i}) - $signed({origin_i[DATA_W-1], origin_i});
    diff_hi = $signed({hi_i[DATA_W-1], hi_i}) - $signed({origin_i[DATA_W-1], origin_i});
    num_lo_d = diff_lo[DATA_W] ? (~diff_lo + 1'b1) : diff_lo;
    num_hi_d = diff_hi[DATA_W] ? (~diff_hi + 1'b1) : diff_hi;
    den_d    = dir_i[DATA_W-1] ? (~dir_i + 1'b1) : dir_i;
    flags_d.num_lo_neg = diff_lo[DATA_W];
    flags_d.num_hi_neg = diff_hi[DATA_W];
    flags_d.dir_neg    = dir_i[DATA_W-1];
    flags_d.dir_zero   = (dir_i == '0);
    flags_d.par_miss   = (origin_i < lo_i) || (origin_i > hi_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_lo_q <= num_lo_d;
    num_hi_q <= num_hi_d;
    den_q    <= den_d;
    flags_q  <= flags_d;
  end

  assign valid_o  = valid_q;
  assign num_lo_o = num_lo_q;
  assign num_hi_o = num_hi_q;
  assign den_o    = den_q;
  assign flags_o  = flags_q;

endmodule

`default_nettype wire

### src/rbsi_slab_div.sv
// pipelined restoring divider, one quotient bit per stage, two dividends
// sharing one divisor; depends on rbsi_pkg
`default_nettype none

module rbsi_slab_div
  import rbsi_pkg::*;
#(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_lo_i,
  input  wire logic [NW-1:0] num_hi_i,
  input  wire logic [DW-1:0] den_i,
  input  wire slab_flags_t   flags_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_lo_o,
  output logic [NW-1:0]      quo_hi_o,
  output slab_flags_t        flags_o
);

  // returns {quotient bit, new remainder}
  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                           input logic          nbit,
                                           input logic [DW-1:0] den);
    logic [DW:0] trial;
    logic [DW:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      div_step = {1'b1, diff[DW-1:0]};
    end else begin
      div_step = {1'b0, trial[DW-1:0]};
    end
  endfunction

  logic              v_q   [NW];
  logic [NW-1:0]     nlo_q [NW];
  logic [NW-1:0]     nhi_q [NW];
  logic [NW-1:0]     qlo_q [NW];
  logic [NW-1:0]     qhi_q [NW];
  logic [DW-1:0]     rlo_q [NW];
  logic [DW-1:0]     rhi_q [NW];
  logic [DW-1:0]     d_q   [NW];
  slab_flags_t       f_q   [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_p;
    logic [NW-1:0] nlo_p, nhi_p, qlo_p, qhi_p, qlo_d, qhi_d;
    logic [DW-1:0] rlo_p, rhi_p, d_p;
    slab_flags_t   f_p;
    logic [DW:0]   st_lo, st_hi;

    if (k == 0) begin : g_first
      assign v_p   = valid_i;
      assign nlo_p = num_lo_i;
      assign nhi_p = num_hi_i;
      assign qlo_p = '0;
      assign qhi_p = '0;
      assign rlo_p = '0;
      assign rhi_p = '0;
      assign d_p   = den_i;
      assign f_p   = flags_i;
    end else begin : g_next
      assign v_p   = v_q[k-1];
      assign nlo_p = nlo_q[k-1];
      assign nhi_p = nhi_q[k-1];
      assign qlo_p = qlo_q[k-1];
      assign qhi_p = qhi_q[k-1];
      assign rlo_p = rlo_q[k-1];
      assign rhi_p = rhi_q[k-1];
      assign d_p   = d_q[k-1];
      assign f_p   = f_q[k-1];
    end

    always_comb begin
      st_lo = div_step(rlo_p, nlo_p[NW-1-k], d_p);
      st_hi = div_step(rhi_p, nhi_p[NW-1-k], d_p);
      qlo_d = qlo_p;
      qhi_d = qhi_p;
      qlo_d[NW-1-k] = st_lo[DW];
      qhi_d[NW-1-k] = st_hi[DW];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      nlo_q[k] <= nlo_p;
      nhi_q[k] <= nhi_p;
      qlo_q[k] <= qlo_d;
      qhi_q[k] <= qhi_d;
      rlo_q[k] <= st_lo[DW-1:0];
      rhi_q[k] <= st_hi[DW-1:0];
      d_q[k]   <= d_p;
      f_q[k]   <= f_p;
    end
  end

  assign valid_o  = v_q[NW-1];
  assign quo_lo_o = qlo_q[NW-1];
  assign quo_hi_o = qhi_q[NW-1];
  assign flags_o  = f_q[NW-1];

endmodule

`default_nettype wire

### src/rbsi_merge.sv
// signs and orders the slab distances, merges the axes and forms the result
// three register stages; depends on rbsi_pkg
`default_nettype none

module rbsi_merge
  import rbsi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned NW        = 49
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] quo_lo_i [AXES],
  input  wire logic [NW-1:0] quo_hi_i [AXES],
  input  wire slab_flags_t   flags_i  [AXES],
  output logic               done_o,
  output logic               hit_o,
  output logic [DATA_W-1:0]  distance_o
);

  localparam int unsigned TW = NW + 2;
  localparam logic signed [TW-1:0] NO_LIMIT = TW'(1) <<< NW;
  localparam logic signed [TW-1:0] SAT_MAX  = TW'(32'sh7FFF_FFFF);
  localparam logic signed [TW-1:0] SAT_MIN  = TW'(-32'sh7FFF_FFFF - 32'sd1);
  localparam logic [DATA_W-1:0]    MISS_DIST = ~((DATA_W'(1) << FRAC_BITS) - DATA_W'(1));

  // stage a: signed, ordered per-axis distances
  logic                 a_v_q;
  logic                 a_miss_d, a_miss_q;
  logic signed [TW-1:0] a_ent_d [AXES];
  logic signed [TW-1:0] a_ext_d [AXES];
  logic signed [TW-1:0] a_ent_q [AXES];
  logic signed [TW-1:0] a_ext_q [AXES];

  always_comb begin
    logic signed [TW-1:0] t1, t2, mag1, mag2;
    a_miss_d = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      mag1 = $signed({2'b00, quo_lo_i[a]});
      mag2 = $signed({2'b00, quo_hi_i[a]});
      t1 = (flags_i[a].num_lo_neg ^ flags_i[a].dir_neg) ? -mag1 : mag1;
      t2 = (flags_i[a].num_hi_neg ^ flags_i[a].dir_neg) ? -mag2 : mag2;
      if (flags_i[a].dir_zero) begin
        a_ent_d[a] = -NO_LIMIT;
        a_ext_d[a] = NO_LIMIT;
        a_miss_d   = a_miss_d | flags_i[a].par_miss;
      end else if (t1 > t2) begin
        a_ent_d[a] = t2;
        a_ext_d[a] = t1;
      end else begin
        a_ent_d[a] = t1;
        a_ext_d[a] = t2;
      end
    end
  end

  // stage b: combine axes and pick the distance
  logic                 b_v_q;
  logic                 b_miss_d, b_miss_q;
  logic signed [TW-1:0] b_t_d, b_t_q;

  always_comb begin
    logic signed [TW-1:0] ent, ext;
    ent = a_ent_q[0];
    ext = a_ext_q[0];
    for (int a = 1; a < AXES; a++) begin
      if (a_ent_q[a] > ent) begin
        ent = a_ent_q[a];
      end
      if (a_ext_q[a] < ext) begin
        ext = a_ext_q[a];
      end
    end
    b_miss_d = a_miss_q || (ent > ext) || (ext < 0);
    b_t_d    = (ent > 0) ? ent : ext;
  end

  // stage c: saturate the distance, or give the miss distance, into the output register
  logic              c_v_q;
  logic              c_hit_d, c_hit_q;
  logic [DATA_W-1:0] c_dist_d, c_dist_q;

  always_comb begin
    c_hit_d = !b_miss_q;
    if (b_miss_q) begin
      c_dist_d = MISS_DIST;
    end else if (b_t_q > SAT_MAX) begin
      c_dist_d = SAT_MAX[DATA_W-1:0];
    end else if (b_t_q < SAT_MIN) begin
      c_dist_d = SAT_MIN[DATA_W-1:0];
    end else begin
      c_dist_d = b_t_q[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_miss_q <= a_miss_d;
    for (int a = 0; a < AXES; a++) begin
      a_ent_q[a] <= a_ent_d[a];
      a_ext_q[a] <= a_ext_d[a];
    end
    b_miss_q <= b_miss_d;
    b_t_q    <= b_t_d;
    c_hit_q  <= c_hit_d;
    c_dist_q <= c_dist_d;
  end

  assign done_o     = c_v_q;
  assign hit_o      = c_hit_q;
  assign distance_o = c_dist_q;

endmodule

`default_nettype wire

### src/ray_box_slab_intersect.sv
// top level of the ray versus axis-aligned box slab test
// depends on rbsi_pkg, rbsi_slab_prep, rbsi_slab_div, rbsi_merge
`default_nettype none

// usage
//  - a ray (origin and direction, signed fixed point with FRAC_BITS fraction
//    bits) is taken at each rising edge with start high and busy low
//  - busy is always low: the pipeline takes one ray every cycle
//  - each ray gives one result: done_o is high for exactly one cycle with
//    hit_o and distance_o valid in that cycle, in the order rays came in
//  - the pipeline is one input stage, 33 + FRAC_BITS divider stages (one
//    quotient bit per stage, which sets the depth), then three merge stages
//  - throughput is one ray per cycle; the receiver cannot stall, so nothing
//    is ever held back
//  - box bounds are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//    no ray is in flight; indexes past the last register are ignored
//  - reset clears the box bounds to zero and empties the pipeline; no
//    result comes out until a ray has been taken
module ray_box_slab_intersect
  import rbsi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [DATA_W-1:0]        cfg_wdata_i,
  // ray input
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [DATA_W-1:0] origin_x_i,
  input  wire logic signed [DATA_W-1:0] origin_y_i,
  input  wire logic signed [DATA_W-1:0] origin_z_i,
  input  wire logic signed [DATA_W-1:0] dir_x_i,
  input  wire logic signed [DATA_W-1:0] dir_y_i,
  input  wire logic signed [DATA_W-1:0] dir_z_i,
  // result
  output logic                          done_o,
  output logic                          hit_o,
  output logic signed [DATA_W-1:0]      distance_o
);

  // shifted numerator width: 33-bit difference plus the fraction bits
  localparam int unsigned NW = DATA_W + 1 + FRAC_BITS;

  logic signed [DATA_W-1:0] box_min_q [AXES];
  logic signed [DATA_W-1:0] box_max_q [AXES];
  logic signed [DATA_W-1:0] origin [AXES];
  logic signed [DATA_W-1:0] dir    [AXES];
  logic                     accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign origin[0] = origin_x_i;
  assign origin[1] = origin_y_i;
  assign origin[2] = origin_z_i;
  assign dir[0]    = dir_x_i;
  assign dir[1]    = dir_y_i;
  assign dir[2]    = dir_z_i;

  // box bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        box_min_q[a] <= '0;
        box_max_q[a] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BOX_MIN_X: box_min_q[0] <= cfg_wdata_i;
        REG_BOX_MIN_Y: box_min_q[1] <= cfg_wdata_i;
        REG_BOX_MIN_Z: box_min_q[2] <= cfg_wdata_i;
        REG_BOX_MAX_X: box_max_q[0] <= cfg_wdata_i;
        REG_BOX_MAX_Y: box_max_q[1] <= cfg_wdata_i;
        REG_BOX_MAX_Z: box_max_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic              prep_v   [AXES];
  logic [DATA_W:0]   prep_nlo [AXES];
  logic [DATA_W:0]   prep_nhi [AXES];
  logic [DATA_W-1:0] prep_den [AXES];
  slab_flags_t       prep_f   [AXES];

  logic              div_v    [AXES];
  logic [NW-1:0]     div_qlo  [AXES];
  logic [NW-1:0]     div_qhi  [AXES];
  slab_flags_t       div_f    [AXES];

  // one prep stage and one divider per axis; all axes run in lockstep
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    rbsi_slab_prep u_prep (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (accept),
      .origin_i (origin[a]),
      .dir_i    (dir[a]),
      .lo_i     (box_min_q[a]),
      .hi_i     (box_max_q[a]),
      .valid_o  (prep_v[a]),
      .num_lo_o (prep_nlo[a]),
      .num_hi_o (prep_nhi[a]),
      .den_o    (prep_den[a]),
      .flags_o  (prep_f[a])
    );

    // numerator is the magnitude shifted up by the fraction bits
    rbsi_slab_div #(
      .NW (NW),
      .DW (DATA_W)
    ) u_div (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (prep_v[a]),
      .num_lo_i ({prep_nlo[a], {FRAC_BITS{1'b0}}}),
      .num_hi_i ({prep_nhi[a], {FRAC_BITS{1'b0}}}),
      .den_i    (prep_den[a]),
      .flags_i  (prep_f[a]),
      .valid_o  (div_v[a]),
      .quo_lo_o (div_qlo[a]),
      .quo_hi_o (div_qhi[a]),
      .flags_o  (div_f[a])
    );
  end

  logic [DATA_W-1:0] merge_dist;

  // axes share timing; the merge valid is the AND of all three axis valids
  rbsi_merge #(
    .FRAC_BITS (FRAC_BITS),
    .NW        (NW)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (div_v[0] && div_v[1] && div_v[2]),
    .quo_lo_i   (div_qlo),
    .quo_hi_i   (div_qhi),
    .flags_i    (div_f),
    .done_o     (done_o),
    .hit_o      (hit_o),
    .distance_o (merge_dist)
  );

  assign distance_o = $signed(merge_dist);

endmodule

`default_nettype wire

### bench/tb_ray_box_slab_intersect.sv
// self-checking bench for ray_box_slab_intersect: directed table, then random rays
// depends on rbsi_pkg and the ray_box_slab_intersect rtl
`default_nettype none

module tb_ray_box_slab_intersect;
  import rbsi_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 37 + FB;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1650;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
    logic               chk;    // expected value given in the row
    logic               hit;
    logic signed [31:0] distance;
  } ray_row_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] distance;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0] cfg_wdata_i = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic done_o, hit_o;
  logic signed [31:0] distance_o;

  // box bounds as the bench sees them, [0..2] min, [3..5] max
  logic signed [31:0] box_bound [6];
  hit_t expected_hits [$];
  int errors = 0;
  int idle_cycles = 0;

  ray_box_slab_intersect #(.FRAC_BITS(FB)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // signed quotient truncated toward zero, at full width
  function automatic longint slab_dist(longint num, longint den);
    longint unsigned nm, dm, q;
    nm = num < 0 ? -num : num;
    dm = den < 0 ? -den : den;
    q = (nm << FB) / dm;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic hit_t predict_hit(ray_row_t r);
    longint enter, leave, t1, t2, t, o, d, lo, hi;
    bit miss;
    hit_t res;
    enter = -(longint'(1) << 62);
    leave = longint'(1) << 62;
    miss = 0;
    for (int a = 0; a < 3; a++) begin
      o = a == 0 ? r.ox : a == 1 ? r.oy : r.oz;
      d = a == 0 ? r.dx : a == 1 ? r.dy : r.dz;
      lo = box_bound[a];
      hi = box_bound[a+3];
      if (d == 0) begin
        // parallel axis: only the slab membership matters
        if (o < lo || o > hi) miss = 1;
      end else begin
        t1 = slab_dist(lo - o, d);
        t2 = slab_dist(hi - o, d);
        if (t1 > t2) begin t = t1; t1 = t2; t2 = t; end
        if (t1 > enter) enter = t1;
        if (t2 < leave) leave = t2;
      end
    end
    if (miss || enter > leave || leave < 0) begin
      res.hit = 0;
      res.distance = -(32'sd1 <<< FB);
    end else begin
      t = enter > 0 ? enter : leave;
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      res.hit = 1;
      res.distance = t[31:0];
    end
    return res;
  endfunction

  // write enable stays high; set_box drops it after the last write
  task automatic write_bound(cfg_reg_e idx, logic signed [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    box_bound[idx] = val;
  endtask

  // order set: swap min and max per axis so that min is below max
  task automatic set_box(logic signed [31:0] mnx, mny, mnz, mxx, mxy, mxz,
                         bit order = 1'b0);
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] tmp;
    lo[0] = mnx; lo[1] = mny; lo[2] = mnz;
    hi[0] = mxx; hi[1] = mxy; hi[2] = mxz;
    if (order)
      for (int a = 0; a < 3; a++)
        if (lo[a] > hi[a]) begin
          tmp = lo[a]; lo[a] = hi[a]; hi[a] = tmp;
        end
    write_bound(REG_BOX_MIN_X, lo[0]);
    write_bound(REG_BOX_MIN_Y, lo[1]);
    write_bound(REG_BOX_MIN_Z, lo[2]);
    write_bound(REG_BOX_MAX_X, hi[0]);
    write_bound(REG_BOX_MAX_Y, hi[1]);
    write_bound(REG_BOX_MAX_Z, hi[2]);
    // an out-of-range index must be ignored
    cfg_we_i <= 1'b1;
    cfg_idx_i <= 3'd7;
    cfg_wdata_i <= $urandom;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // send one item, random gap before it; start stays high across back-to-back items
  task automatic send_ray(ray_row_t r);
    hit_t e;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    origin_x_i <= r.ox; origin_y_i <= r.oy; origin_z_i <= r.oz;
    dir_x_i <= r.dx; dir_y_i <= r.dy; dir_z_i <= r.dz;
    e = predict_hit(r);
    if (r.chk && (e.hit !== r.hit || e.distance !== r.distance)) begin
      $display("%0t table row disagrees: expected %0d/%0d predicted %0d/%0d",
               $time, r.hit, r.distance, e.hit, e.distance);
      errors++;
    end
    if (r.chk) begin e.hit = r.hit; e.distance = r.distance; end
    do @(posedge clk_i); while (busy);
    expected_hits.push_back(e);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // mostly coordinates around the origin, with some full-range random values and some at the extremes
  function automatic logic signed [31:0] rnd_coord(int mode);
    case (mode)
      0: return $signed($urandom_range(0, 20 << FB)) - (10 << FB);
      1: return $urandom;
      default: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_dir();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return 0;
    if (k < 7) return $signed($urandom_range(0, 4 << FB)) - (2 << FB);
    if (k < 8) return ($urandom_range(0, 1)) ? 32'sd1 : -32'sd1;
    if (k < 9) return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom;
  endfunction

  // result checker: receiver cannot stall
  always @(posedge clk_i) begin
    hit_t e;
    if (rst_ni && done_o) begin
      if (expected_hits.size() == 0) begin
        $display("%0t unexpected result: expected none, actual hit %0d dist %0d",
                 $time, hit_o, distance_o);
        errors++;
      end else begin
        e = expected_hits.pop_front();
        if (hit_o !== e.hit) begin
          $display("%0t hit mismatch: expected %0d actual %0d", $time, e.hit, hit_o);
          errors++;
        end
        if (distance_o !== e.distance) begin
          $display("%0t distance mismatch: expected %0d actual %0d",
                   $time, e.distance, distance_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no ray accepted, no result and no configuration write
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  localparam logic signed [31:0] ONE = 32'sh00010000;
  localparam logic signed [31:0] MX = 32'sh7fffffff;
  localparam logic signed [31:0] MN = 32'sh80000000;
  localparam logic signed [31:0] MISS = -32'sh00010000;

  ray_row_t reset_rows [3];
  ray_row_t unit_rows [12];

  initial begin
    ray_row_t r;
    for (int i = 0; i < 6; i++) box_bound[i] = 0;
    // reset box is a single point at the origin
    reset_rows[0] = '{0, 0, 0, 0, 0, 0, 1, 1, MX};       // no axis limits
    reset_rows[1] = '{ONE, 0, 0, 0, 0, 0, 1, 0, MISS};   // parallel, outside
    reset_rows[2] = '{0, 0, 0, ONE, 0, 0, 1, 1, 0};      // touching, exit zero
    // unit box [-1,1]^3
    unit_rows[0] = '{-(2*ONE), 0, 0, ONE, 0, 0, 1, 1, ONE};
    unit_rows[1] = '{2*ONE, 0, 0, ONE, 0, 0, 1, 0, MISS};    // box behind
    unit_rows[2] = '{0, 0, 0, ONE, 0, 0, 1, 1, ONE};         // inside, exit
    unit_rows[3] = '{0, 2*ONE, 0, ONE, 0, 0, 1, 0, MISS};    // parallel miss
    unit_rows[4] = '{MN, 0, 0, 32'sd1, 0, 0, 1, 1, MX};      // saturates
    unit_rows[5] = '{MX, MN, MX, MN, MX, MN, 0, 0, 0};
    unit_rows[6] = '{MN, MX, MN, MX, MN, MX, 0, 0, 0};
    unit_rows[7] = '{-(2*ONE), -(2*ONE), 0, ONE, -ONE, 0, 0, 0, 0};
    unit_rows[8] = '{-(2*ONE), -(2*ONE), -(2*ONE), ONE, ONE, ONE, 0, 0, 0};
    unit_rows[9] = '{0, 0, 0, -1, 32'sd1, -1, 0, 0, 0};
    unit_rows[10] = '{-(2*ONE), 2*ONE, 0, ONE, ONE, 0, 0, 0, 0}; // diagonal past the corner, misses
    unit_rows[11] = '{32'shffffffff, 0, 0, 0, MN, MX, 0, 0, 0};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (reset_rows[i]) send_ray(reset_rows[i]);
    drain();
    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    foreach (unit_rows[i]) send_ray(unit_rows[i]);
    drain();
    // inverted box
    set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
    send_ray('{0, 0, 0, 0, 0, 0, 1, 0, MISS});
    send_ray('{-(3*ONE), 0, 0, ONE, ONE, ONE, 0, 0, 0});
    drain();
    // full-range box
    set_box(MN, MN, MN, MX, MX, MX);
    send_ray('{MN, MN, MN, 0, 0, 0, 1, 1, MX});
    send_ray('{MX, MN, 0, MN, MX, 32'sd1, 0, 0, 0});
    drain();

    for (int phase = 0; phase < 11; phase++) begin
      int mode;
      mode = phase % 4 == 3 ? 1 : 0;
      // mostly proper boxes: order min below max
      set_box(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
              rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
              phase % 4 != 3);
      for (int i = 0; i < N_RANDOM / 11; i++) begin
        int om;
        om = $urandom_range(0, 9) < 8 ? 0 : $urandom_range(1, 2);
        r.ox = rnd_coord(om); r.oy = rnd_coord(om); r.oz = rnd_coord(om);
        r.dx = rnd_dir(); r.dy = rnd_dir(); r.dz = rnd_dir();
        r.chk = 0; r.hit = 0; r.distance = 0;
        send_ray(r);
      end
      drain();
    end

    if (errors == 0 && expected_hits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

`default_nettype wire
